@@ design/crq_pkg.sv @@
// Shared types and constants for the cascaded three-ring queue.
package crq_pkg;

  localparam int NUM_QUEUES = 3;
  localparam int QIDX_W     = 2;
  localparam int DATA_W     = 32;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_PUSHED    = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_POPPED    = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic                     kind;
    logic signed [DATA_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] popped_value;
    logic [QIDX_W-1:0]        which_queue;
  } out_beat_t;

  typedef struct packed {
    status_t           status;
    logic [QIDX_W-1:0] which_queue;
  } res_t;

endpackage

@@ design/crq_mem.sv @@
// Synchronous single-port store holding the entries of all three queues.
module crq_mem #(
  parameter int QUEUE_DEPTH = 4,
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int AW = crq_pkg::QIDX_W + PW,
  localparam int ENTRIES = crq_pkg::NUM_QUEUES << PW
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic                             rd_en,
  input  logic [AW-1:0]                    addr,
  input  logic signed [crq_pkg::DATA_W-1:0] wr_data,
  output logic signed [crq_pkg::DATA_W-1:0] rd_data
);

  logic signed [crq_pkg::DATA_W-1:0] mem [ENTRIES];
  logic signed [crq_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/crq_ctrl.sv @@
// Queue selection, pointer and occupancy bookkeeping, and the result register.
module crq_ctrl #(
  parameter int QUEUE_DEPTH = 4,
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int OW = $clog2(QUEUE_DEPTH + 1),
  localparam int AW = crq_pkg::QIDX_W + PW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output crq_pkg::res_t     res,
  output logic              mem_wr_en,
  output logic              mem_rd_en,
  output logic [AW-1:0]     mem_addr
);

  localparam logic [OW-1:0] OCC_FULL = OW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

  logic [PW-1:0] rd_ptr_r [crq_pkg::NUM_QUEUES];
  logic [PW-1:0] rd_ptr_nxt [crq_pkg::NUM_QUEUES];
  logic [PW-1:0] wr_ptr_r [crq_pkg::NUM_QUEUES];
  logic [PW-1:0] wr_ptr_nxt [crq_pkg::NUM_QUEUES];
  logic [OW-1:0] occ_r [crq_pkg::NUM_QUEUES];
  logic [OW-1:0] occ_nxt [crq_pkg::NUM_QUEUES];

  logic                       out_valid_r;
  logic                       out_valid_nxt;
  crq_pkg::res_t              res_r;
  crq_pkg::res_t              res_nxt;
  logic                       accept;
  logic                       sel_found;
  logic [crq_pkg::QIDX_W-1:0] sel_q;
  logic [PW-1:0]              sel_ptr;
  logic [OW+1:0]              occ_sum;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    sel_found = 1'b0;
    sel_q     = '0;
    sel_ptr   = '0;
    for (int q = 0; q < crq_pkg::NUM_QUEUES; q++) begin
      if (!sel_found && ((in_kind == crq_pkg::KIND_PUSH) ? (occ_r[q] != OCC_FULL)
                                                         : (occ_r[q] != '0))) begin
        sel_found = 1'b1;
        sel_q     = crq_pkg::QIDX_W'(q);
        sel_ptr   = (in_kind == crq_pkg::KIND_PUSH) ? wr_ptr_r[q] : rd_ptr_r[q];
      end
    end
  end

  always_comb begin
    for (int q = 0; q < crq_pkg::NUM_QUEUES; q++) begin
      rd_ptr_nxt[q] = rd_ptr_r[q];
      wr_ptr_nxt[q] = wr_ptr_r[q];
      occ_nxt[q]    = occ_r[q];
      if (accept && sel_found && (sel_q == crq_pkg::QIDX_W'(q))) begin
        if (in_kind == crq_pkg::KIND_PUSH) begin
          wr_ptr_nxt[q] = (wr_ptr_r[q] == PTR_LAST) ? '0 : wr_ptr_r[q] + 1'b1;
          occ_nxt[q]    = occ_r[q] + 1'b1;
        end else begin
          rd_ptr_nxt[q] = (rd_ptr_r[q] == PTR_LAST) ? '0 : rd_ptr_r[q] + 1'b1;
          occ_nxt[q]    = occ_r[q] - 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (in_kind == crq_pkg::KIND_PUSH) begin
      res_nxt.status = sel_found ? crq_pkg::ST_PUSHED : crq_pkg::ST_OVERFLOW;
    end else begin
      res_nxt.status = sel_found ? crq_pkg::ST_POPPED : crq_pkg::ST_UNDERFLOW;
    end
    res_nxt.which_queue = sel_found ? sel_q : '0;
    out_valid_nxt       = accept || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int q = 0; q < crq_pkg::NUM_QUEUES; q++) begin
        rd_ptr_r[q] <= '0;
        wr_ptr_r[q] <= '0;
        occ_r[q]    <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      for (int q = 0; q < crq_pkg::NUM_QUEUES; q++) begin
        rd_ptr_r[q] <= rd_ptr_nxt[q];
        wr_ptr_r[q] <= wr_ptr_nxt[q];
        occ_r[q]    <= occ_nxt[q];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;
  assign mem_wr_en = accept && sel_found && (in_kind == crq_pkg::KIND_PUSH);
  assign mem_rd_en = accept && sel_found && (in_kind == crq_pkg::KIND_POP);
  assign mem_addr  = {sel_q, sel_ptr};

  assign occ_sum = (OW+2)'(occ_r[0]) + (OW+2)'(occ_r[1]) + (OW+2)'(occ_r[2]);

  a_occ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r[0] <= OCC_FULL) && (occ_r[1] <= OCC_FULL) && (occ_r[2] <= OCC_FULL))
    else $error("queue occupancy above depth");

  a_overflow_all_full: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (res_nxt.status == crq_pkg::ST_OVERFLOW)) |->
      ((occ_r[0] == OCC_FULL) && (occ_r[1] == OCC_FULL) && (occ_r[2] == OCC_FULL)))
    else $error("overflow reported while a queue had room");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (res_nxt.status == crq_pkg::ST_PUSHED)) |=>
      (occ_sum == $past(occ_sum) + 1'b1))
    else $error("push did not add one entry");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (res_nxt.status == crq_pkg::ST_POPPED)) |=>
      (occ_sum == $past(occ_sum) - 1'b1))
    else $error("pop did not remove one entry");

endmodule

@@ design/cascaded_three_ring_queue.sv @@
// Top level of the cascaded three-ring queue: control, shared store and result assembly.
// The result beat is registered and valid in the cycle after its item is accepted.
// Throughput: one item per cycle when not stalled; at most one store read or write per item.
// An item is taken whenever the result register is empty or is being drained.
// Reset clears pointers, occupancy counts and the result valid; store contents stay undefined.
module cascaded_three_ring_queue #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  crq_pkg::in_beat_t  in_beat,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output crq_pkg::out_beat_t out_beat
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int AW = crq_pkg::QIDX_W + PW;

  crq_pkg::res_t                     res;
  logic                              mem_wr_en;
  logic                              mem_rd_en;
  logic [AW-1:0]                     mem_addr;
  logic signed [crq_pkg::DATA_W-1:0] rd_data;

  crq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_beat.kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res),
    .mem_wr_en (mem_wr_en),
    .mem_rd_en (mem_rd_en),
    .mem_addr  (mem_addr)
  );

  crq_mem #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .rd_en   (mem_rd_en),
    .addr    (mem_addr),
    .wr_data (in_beat.value),
    .rd_data (rd_data)
  );

  always_comb begin
    out_beat.status       = res.status;
    out_beat.which_queue  = res.which_queue;
    out_beat.popped_value = (res.status == crq_pkg::ST_POPPED) ? rd_data : '0;
  end

endmodule

@@ dv/cascaded_three_ring_queue_tb.sv @@
// Self-checking testbench for the cascaded three-ring queue: directed and random push/pop traffic.
module cascaded_three_ring_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH = 4;
  localparam int IDLE_LIMIT  = 2000;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  crq_pkg::in_beat_t  in_beat   = '0;
  logic               in_stall;
  logic               out_valid;
  logic               out_stall = 1'b0;
  crq_pkg::out_beat_t out_beat;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int error_count        = 0;
  int idle_cycles        = 0;
  int n_pushed, n_overflow, n_popped, n_underflow;

  logic signed [crq_pkg::DATA_W-1:0] ring_word [crq_pkg::NUM_QUEUES][QUEUE_DEPTH];
  int head_ptr   [crq_pkg::NUM_QUEUES];
  int tail_ptr   [crq_pkg::NUM_QUEUES];
  int fill_count [crq_pkg::NUM_QUEUES];
  crq_pkg::out_beat_t pending_results [$];

  cascaded_three_ring_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_beat  (in_beat),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int next_slot(input int p);
    return (p + 1 == QUEUE_DEPTH) ? 0 : p + 1;
  endfunction

  function automatic crq_pkg::out_beat_t predict_queue_op(input crq_pkg::in_beat_t item);
    crq_pkg::out_beat_t res;
    bit                 done;
    done             = 1'b0;
    res.popped_value = '0;
    res.which_queue  = '0;
    if (item.kind == crq_pkg::KIND_PUSH) begin
      res.status = crq_pkg::ST_OVERFLOW;
      for (int q = 0; q < crq_pkg::NUM_QUEUES; q++) begin
        if (!done && fill_count[q] < QUEUE_DEPTH) begin
          ring_word[q][tail_ptr[q]] = item.value;
          tail_ptr[q]    = next_slot(tail_ptr[q]);
          fill_count[q]++;
          res.status      = crq_pkg::ST_PUSHED;
          res.which_queue = crq_pkg::QIDX_W'(q);
          done            = 1'b1;
        end
      end
    end else begin
      res.status = crq_pkg::ST_UNDERFLOW;
      for (int q = 0; q < crq_pkg::NUM_QUEUES; q++) begin
        if (!done && fill_count[q] != 0) begin
          res.popped_value = ring_word[q][head_ptr[q]];
          head_ptr[q]      = next_slot(head_ptr[q]);
          fill_count[q]--;
          res.status      = crq_pkg::ST_POPPED;
          res.which_queue = crq_pkg::QIDX_W'(q);
          done            = 1'b1;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [crq_pkg::DATA_W-1:0] got,
                                 input logic [crq_pkg::DATA_W-1:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Inputs are predicted before outputs are checked, so a same-edge beat never races.
  always @(posedge clk) begin
    crq_pkg::out_beat_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = predict_queue_op(in_beat);
        pending_results.push_back(want);
        case (want.status)
          crq_pkg::ST_PUSHED:   n_pushed++;
          crq_pkg::ST_OVERFLOW: n_overflow++;
          crq_pkg::ST_POPPED:   n_popped++;
          default:              n_underflow++;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected beat", out_beat.popped_value, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_beat.status !== want.status)
            report_mismatch("status", out_beat.status, want.status);
          if (out_beat.popped_value !== want.popped_value)
            report_mismatch("popped_value", out_beat.popped_value, want.popped_value);
          if (out_beat.which_queue !== want.which_queue)
            report_mismatch("which_queue", out_beat.which_queue, want.which_queue);
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles without a beat", IDLE_LIMIT);
        $display("[cascaded_three_ring_queue] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic logic [crq_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic kind, input logic [crq_pkg::DATA_W-1:0] word);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_beat.kind   <= kind;
    in_beat.value  <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_pop_after_reset();
    send_item(crq_pkg::KIND_POP, 32'hffff_ffff);
  endtask

  task automatic test_fill_and_overflow();
    logic [crq_pkg::DATA_W-1:0] words [12];
    words = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
              32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 32'hffff_fffe,
              32'h8000_0001, 32'h7fff_fffe, 32'h1234_5678, 32'hedcb_a987};
    foreach (words[i]) send_item(crq_pkg::KIND_PUSH, words[i]);
    send_item(crq_pkg::KIND_PUSH, 32'h7fff_ffff);
  endtask

  task automatic test_drain_in_rank_order();
    repeat (13) send_item(crq_pkg::KIND_POP, $urandom);
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    int push_bias;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    push_bias          = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) push_bias = $urandom_range(15, 85);
      send_item(($urandom_range(99) < push_bias) ? crq_pkg::KIND_PUSH : crq_pkg::KIND_POP,
                pick_word());
    end
  endtask

  task automatic test_pause_until_drained();
    sender_idle_pct    = 0;
    receiver_stall_pct = 54;
    repeat (6) send_item(crq_pkg::KIND_PUSH, pick_word());
    wait_drained();
    repeat (6) send_item(crq_pkg::KIND_POP, pick_word());
  endtask

  initial begin
    for (int q = 0; q < crq_pkg::NUM_QUEUES; q++) begin
      head_ptr[q]   = 0;
      tail_ptr[q]   = 0;
      fill_count[q] = 0;
    end
    n_pushed    = 0;
    n_overflow  = 0;
    n_popped    = 0;
    n_underflow = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pop_after_reset();
    test_fill_and_overflow();
    test_drain_in_rank_order();
    test_random_traffic(190, 0, 0);
    test_random_traffic(190, 54, 0);
    test_pause_until_drained();
    test_random_traffic(190, 0, 54);
    test_random_traffic(180, 38, 38);

    wait_drained();
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("missing beats", pending_results.size(), 0);

    $display("covered %0d pushes, %0d overflows, %0d pops, %0d underflows",
             n_pushed, n_overflow, n_popped, n_underflow);
    $display("idle and stall mixes: none, sender only, receiver only, both");
    if (error_count == 0) begin
      $display("[cascaded_three_ring_queue] OK");
    end else begin
      $display("[cascaded_three_ring_queue] ERROR");
    end
    $finish;
  end

endmodule

@@ cascaded_three_ring_queue.f @@
design/crq_pkg.sv
design/crq_mem.sv
design/crq_ctrl.sv
design/cascaded_three_ring_queue.sv
dv/cascaded_three_ring_queue_tb.sv
